// File: design/i2cm_pkg.sv
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master transaction engine.
// ---------------------------------------------------------------------------
package i2cm_pkg;

   localparam int TimeoutBits = 16;
   localparam int QueueDepth  = 2;

   localparam logic [2:0] FUNC_NONE      = 3'd0;
   localparam logic [2:0] FUNC_WR_BYTE   = 3'd1;
   localparam logic [2:0] FUNC_WR_MULTI  = 3'd2;
   localparam logic [2:0] FUNC_WR_REG    = 3'd3;
   localparam logic [2:0] FUNC_RD_BYTE   = 3'd4;
   localparam logic [2:0] FUNC_RD_REG    = 3'd5;

   localparam logic [1:0] SEG_ADDR_W = 2'd0;
   localparam logic [1:0] SEG_REG    = 2'd1;
   localparam logic [1:0] SEG_DATA   = 2'd2;
   localparam logic [1:0] SEG_ADDR_R = 2'd3;

   localparam logic [0:0] REG_ACK_TIMEOUT = 1'd0;

   typedef struct packed {
      logic [2:0] func;
      logic [6:0] slave_address;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic [7:0] byte_count;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic       error;
      logic [7:0] read_data;
      logic       data_taken;
   } rsp_type;

   // classified tick handed from front to back
   typedef struct packed {
      logic       is_cmd;
      logic [2:0] func;
      logic [6:0] slave_address;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic [7:0] byte_count;
      logic       sda_in;
   } tick_type;

   typedef enum logic [8:0] {
      PH_IDLE     = 9'b000000001,
      PH_START    = 9'b000000010,
      PH_BIT      = 9'b000000100,
      PH_ACKSETUP = 9'b000001000,
      PH_POLL     = 9'b000010000,
      PH_ACKHOLD  = 9'b000100000,
      PH_RBIT     = 9'b001000000,
      PH_RNACK    = 9'b010000000,
      PH_STOP     = 9'b100000000
   } phase_type;

endpackage

// File: design/i2cm_stream_if.sv
// ---------------------------------------------------------------------------
// i2cm_stream_if
// Valid/ready channel carrying one payload word.
// ---------------------------------------------------------------------------
interface i2cm_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/i2cm_front.sv
// ---------------------------------------------------------------------------
// i2cm_front
// Accept requests, classify the command code, and queue ticks for the back.
// ---------------------------------------------------------------------------
module i2cm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  i2cm_pkg::req_type  req_data,
   output logic               q_valid,
   input  logic               q_ready,
   output i2cm_pkg::tick_type q_data
);
   import i2cm_pkg::*;

   tick_type   entry_ff [QueueDepth];
   logic [0:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   tick_type   cls;

   // classify: only codes one to five start a transaction
   always_comb begin
      cls.func          = req_data.func;
      cls.slave_address = req_data.slave_address;
      cls.reg_addr      = req_data.reg_addr;
      cls.wr_data       = req_data.wr_data;
      cls.byte_count    = req_data.byte_count;
      cls.sda_in        = req_data.sda_in;
      cls.is_cmd        = (req_data.func >= FUNC_WR_BYTE) && (req_data.func <= FUNC_RD_REG);
   end

   assign req_ready = (count_ff != 2'(QueueDepth));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store queue entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QueueDepth)) else $error("queue count overflow");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'(QueueDepth)) |-> !push) else $error("push into full queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("count not tracking push");
endmodule

// File: design/i2cm_back.sv
// ---------------------------------------------------------------------------
// i2cm_back
// Bit sequencer: run one timing unit per tick and register the result.
// ---------------------------------------------------------------------------
module i2cm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  i2cm_pkg::tick_type q_data,
   input  logic [15:0]        ack_timeout_units,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output i2cm_pkg::rsp_type  rsp_data
);
   import i2cm_pkg::*;

   localparam logic [TimeoutBits-1:0] CountMax = '1;

   phase_type            phase_ff, phase_in;
   logic [1:0]           step_ff, step_in, seg_ff, seg_in;
   logic [2:0]           bit_ff, bit_in, cmd_ff, cmd_in;
   logic [7:0]           shift_ff, shift_in, left_ff, left_in;
   logic [7:0]           reg_ff, reg_in, data_ff, data_in, rx_ff, rx_in;
   logic [6:0]           addr_ff, addr_in;
   logic [TimeoutBits-1:0] tmo_ff, tmo_in;
   logic                 scl_ff, scl_in, sda_ff, sda_in_l, nack_ff, nack_in;
   logic                 out_valid_ff;
   rsp_type              out_ff, res;
   logic                 fire;

   // a result slot is free when empty or being taken
   assign q_ready   = !out_valid_ff || rsp_ready;
   assign fire      = q_valid && q_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic             done, err, taken, busy;
      logic [1:0]       nseg;
      logic             do_begin;
      phase_in = phase_ff; step_in = step_ff; seg_in = seg_ff; bit_in = bit_ff;
      cmd_in = cmd_ff; shift_in = shift_ff; left_in = left_ff; reg_in = reg_ff;
      data_in = data_ff; rx_in = rx_ff; addr_in = addr_ff; tmo_in = tmo_ff;
      scl_in = scl_ff; sda_in_l = sda_ff; nack_in = nack_ff;
      done = 1'b0; err = 1'b0; taken = 1'b0; do_begin = 1'b0; nseg = seg_ff;

      // latch a command while idle
      if (phase_ff == PH_IDLE && q_data.is_cmd) begin
         cmd_in = q_data.func; addr_in = q_data.slave_address;
         reg_in = q_data.reg_addr; data_in = q_data.wr_data;
         left_in = q_data.byte_count;
         seg_in = (q_data.func == FUNC_RD_BYTE) ? SEG_ADDR_R : SEG_ADDR_W;
         nack_in = 1'b0; phase_in = PH_START; step_in = 2'd0;
      end
      busy = (phase_in != PH_IDLE);

      case (phase_in)
         PH_START: begin
            case (step_in)
               2'd0: scl_in = 1'b0;
               2'd1: sda_in_l = 1'b1;
               2'd2: scl_in = 1'b1;
               default: sda_in_l = 1'b0;
            endcase
            if (step_in == 2'd3) begin
               do_begin = 1'b1; nseg = seg_in;
            end else step_in = step_in + 2'd1;
         end
         PH_BIT: begin
            if (step_in == 2'd0) begin
               if (seg_in == SEG_DATA && cmd_in == FUNC_WR_MULTI && bit_in == 3'd7) begin
                  shift_in = q_data.wr_data; taken = 1'b1;
               end
               scl_in = 1'b0;
            end else if (step_in == 2'd1) sda_in_l = shift_in[bit_in];
            else if (step_in == 2'd2) scl_in = 1'b1;
            if (step_in == 2'd3) begin
               step_in = 2'd0;
               if (bit_in == 3'd0) phase_in = PH_ACKSETUP;
               else bit_in = bit_in - 3'd1;
            end else step_in = step_in + 2'd1;
         end
         PH_ACKSETUP: begin
            if (step_in == 2'd0) begin
               scl_in = 1'b0; sda_in_l = 1'b1; step_in = 2'd1;
            end else begin
               phase_in = PH_POLL; step_in = 2'd0; tmo_in = '0;
            end
         end
         PH_POLL: begin
            scl_in = 1'b1;
            if (!q_data.sda_in) begin
               phase_in = PH_ACKHOLD; step_in = 2'd0;
            end else if (32'(tmo_in) > 32'(ack_timeout_units) || tmo_in == CountMax) begin
               nack_in = 1'b1; phase_in = PH_STOP; step_in = 2'd0;
            end else tmo_in = tmo_in + 1'b1;
         end
         PH_ACKHOLD: begin
            if (step_in == 2'd0) step_in = 2'd1;
            else begin
               // choose the next byte after an ACK
               case (seg_in)
                  SEG_ADDR_R: begin
                     phase_in = PH_RBIT; step_in = 2'd0; bit_in = 3'd7; shift_in = '0;
                  end
                  SEG_ADDR_W: begin
                     if (cmd_in == FUNC_WR_BYTE) begin
                        do_begin = 1'b1; nseg = SEG_DATA;
                     end else if (cmd_in == FUNC_WR_MULTI) begin
                        if (left_in == 8'd0) begin
                           phase_in = PH_STOP; step_in = 2'd0;
                        end else begin
                           do_begin = 1'b1; nseg = SEG_DATA;
                        end
                     end else begin
                        do_begin = 1'b1; nseg = SEG_REG;
                     end
                  end
                  SEG_REG: begin
                     if (cmd_in == FUNC_RD_REG) begin
                        seg_in = SEG_ADDR_R; phase_in = PH_START; step_in = 2'd0;
                     end else begin
                        do_begin = 1'b1; nseg = SEG_DATA;
                     end
                  end
                  default: begin
                     if (cmd_in == FUNC_WR_MULTI) begin
                        left_in = left_in - 8'd1;
                        if (left_in == 8'd0) begin
                           phase_in = PH_STOP; step_in = 2'd0;
                        end else begin
                           do_begin = 1'b1; nseg = SEG_DATA;
                        end
                     end else begin
                        phase_in = PH_STOP; step_in = 2'd0;
                     end
                  end
               endcase
            end
         end
         PH_RBIT: begin
            if (step_in == 2'd0) begin
               scl_in = 1'b0; sda_in_l = 1'b1;
            end else if (step_in == 2'd2) scl_in = 1'b1;
            if (step_in == 2'd3) begin
               shift_in[bit_in] = shift_in[bit_in] | q_data.sda_in;
               step_in = 2'd0;
               if (bit_in == 3'd0) begin
                  rx_in = shift_in; phase_in = PH_RNACK;
               end else bit_in = bit_in - 3'd1;
            end else step_in = step_in + 2'd1;
         end
         PH_RNACK: begin
            if (step_in == 2'd0) scl_in = 1'b0;
            else if (step_in == 2'd1) sda_in_l = 1'b1;
            else if (step_in == 2'd2) scl_in = 1'b1;
            if (step_in == 2'd3) begin
               phase_in = PH_STOP; step_in = 2'd0;
            end else step_in = step_in + 2'd1;
         end
         PH_STOP: begin
            case (step_in)
               2'd0: scl_in = 1'b0;
               2'd1: sda_in_l = 1'b0;
               2'd2: scl_in = 1'b1;
               default: sda_in_l = 1'b1;
            endcase
            if (step_in == 2'd3) begin
               done = 1'b1; err = nack_in; nack_in = 1'b0;
               phase_in = PH_IDLE; step_in = 2'd0; bit_in = 3'd7;
            end else step_in = step_in + 2'd1;
         end
         default: ;
      endcase

      // load the next byte to send
      if (do_begin) begin
         seg_in = nseg; phase_in = PH_BIT; step_in = 2'd0; bit_in = 3'd7;
         case (nseg)
            SEG_ADDR_W: shift_in = {addr_in, 1'b0};
            SEG_ADDR_R: shift_in = {addr_in, 1'b1};
            SEG_REG:    shift_in = reg_in;
            default:    shift_in = data_in;
         endcase
      end

      res.scl_out = scl_in; res.sda_out = sda_in_l; res.busy_res = busy;
      res.done_res = done; res.error = err; res.read_data = rx_in;
      res.data_taken = taken;
   end

   // advance sequencer state on each tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; step_ff <= '0; seg_ff <= '0; bit_ff <= 3'd7;
         cmd_ff <= '0; shift_ff <= '0; left_ff <= '0; reg_ff <= '0;
         data_ff <= '0; rx_ff <= '0; addr_ff <= '0; tmo_ff <= '0;
         scl_ff <= 1'b1; sda_ff <= 1'b1; nack_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff <= phase_in; step_ff <= step_in; seg_ff <= seg_in;
            bit_ff <= bit_in; cmd_ff <= cmd_in; shift_ff <= shift_in;
            left_ff <= left_in; reg_ff <= reg_in; data_ff <= data_in;
            rx_ff <= rx_in; addr_ff <= addr_in; tmo_ff <= tmo_in;
            scl_ff <= scl_in; sda_ff <= sda_in_l; nack_ff <= nack_in;
         end
         if (fire) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   // hold result register
   always_ff @(posedge clock) begin
      if (fire) out_ff <= res;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff)) else $error("phase not one-hot");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(out_ff)) else $error("result changed in stall");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && res.done_res) |=> (phase_ff == PH_IDLE)) else $error("done without idle");
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (scl_ff && sda_ff)) else $error("lines low while idle");
endmodule

// File: design/i2c_master_transaction_engine.sv
// ---------------------------------------------------------------------------
// i2c_master_transaction_engine
// I2C master with 7-bit addressing, advanced one timing unit per request.
//
//   channel | dir | handshake       | payload
//   req     | in  | valid/ready     | func, address, reg, data, count, sda
//   rsp     | out | valid/ready     | scl, sda, busy, done, error, data, taken
//   csr     | in  | APB, pready = 1 | ack_timeout_units at address 0
//
// One request per cycle while responses are taken; each request yields one response
// after passing a two-entry queue and then a registered sequencer output.
// Reset is synchronous and returns the sequencer to idle with lines high.
// A stalled response holds the sequencer; the queue keeps accepting until full.
// ---------------------------------------------------------------------------
module i2c_master_transaction_engine (
   input  logic        clock,
   input  logic        reset,
   i2cm_stream_if.sink   req,
   i2cm_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import i2cm_pkg::*;

   logic [15:0] timeout_ff;
   logic        q_valid, q_ready;
   tick_type    q_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'(REG_ACK_TIMEOUT * 4)) ? {16'd0, timeout_ff} : 32'd0;

   // write timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 16'd48;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == 2'(REG_ACK_TIMEOUT * 4)) begin
         timeout_ff <= csr_pwdata[15:0];
      end
   end

   i2cm_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   i2cm_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .ack_timeout_units(timeout_ff),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
   );
endmodule
